// File: rtl/core/cpi_pkg.sv
`timescale 1ns / 1ps
package cpi_pkg;
   localparam int COORD_WIDTH = 24;
   localparam int RADIUS_WIDTH = 23;
   localparam int RR_WIDTH = 2 * RADIUS_WIDTH;
   localparam int ROOT_WIDTH = RADIUS_WIDTH;

   // one circle request, fields in transfer order (center_x at the MSB end)
   typedef struct packed {
      logic [COORD_WIDTH-1:0]  center_x;
      logic [COORD_WIDTH-1:0]  center_y;
      logic [COORD_WIDTH-1:0]  center_z;
      logic [RADIUS_WIDTH-1:0] radius;
   } circle_req_type;

   // one waypoint
   typedef struct packed {
      logic [COORD_WIDTH-1:0] point_x;
      logic [COORD_WIDTH-1:0] point_y;
      logic [COORD_WIDTH-1:0] point_z;
      logic                   last_point;
   } waypoint_rsp_type;
endpackage

// File: rtl/core/cpi_sqrt.sv
`timescale 1ns / 1ps
// Pipelined floor square root: one result bit per stage, stall-aware.
module cpi_sqrt
   import cpi_pkg::*;
#(
   parameter int TAG_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [RR_WIDTH-1:0]   in_rad,
   input  logic [TAG_WIDTH-1:0]  in_tag,
   output logic                  out_valid,
   output logic [ROOT_WIDTH-1:0] out_root,
   output logic [TAG_WIDTH-1:0]  out_tag
);
   localparam int N = ROOT_WIDTH;
   logic [N:0]            vld_ff;
   logic [RR_WIDTH-1:0]   rem_ff [N+1];
   logic [ROOT_WIDTH-1:0] res_ff [N+1];
   logic [TAG_WIDTH-1:0]  tag_ff [N+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[N-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= in_rad;
         res_ff[0] <= '0;
         tag_ff[0] <= in_tag;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_stage
      localparam int B = N - 1 - i;
      logic [RR_WIDTH+1:0] trial_in;
      logic [RR_WIDTH+1:0] rem_ext;
      always_comb begin
         trial_in = ({2'b0, RR_WIDTH'(res_ff[i])} << (B + 1))
                  + ({{(RR_WIDTH+1){1'b0}}, 1'b1} << (2 * B));
         rem_ext = {2'b0, rem_ff[i]};
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            tag_ff[i+1] <= tag_ff[i];
            if (rem_ext >= trial_in) begin
               rem_ff[i+1] <= RR_WIDTH'(rem_ext - trial_in);
               res_ff[i+1] <= res_ff[i] | (ROOT_WIDTH'(1) << B);
            end else begin
               rem_ff[i+1] <= rem_ff[i];
               res_ff[i+1] <= res_ff[i];
            end
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign out_root  = res_ff[N];
   assign out_tag   = tag_ff[N];
endmodule

// File: rtl/core/circle_path_interpolator_top.sv
`timescale 1ns / 1ps
// Circle path interpolator. Each accepted circle (center x/y/z, radius, Q.8)
// yields 2*HALF_POINTS waypoints, one per cycle when the result side is ready:
// upper half from cx+r stepping down by floor(r/(HALF_POINTS/2)), y = cy+sqrt,
// then lower half from cx-r stepping up, y = cy-sqrt; z passes through; the
// final waypoint has last_point set. A new circle is taken as the sequencer
// issues the last point of the previous one; in the cycle after each transfer
// the sequencer computes the step, then issues one point per cycle while the
// pipe advances. Points pass through the step, issue, multiply, radicand,
// bit-per-stage square root and saturation stages to the output.
// A stall freezes every stage from point issue to the output; the step
// calculation and the taking of a request while idle do not wait on it.
module circle_path_interpolator_top
   import cpi_pkg::*;
#(
   parameter int HALF_POINTS = 18
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  circle_req_type   req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output waypoint_rsp_type rsp_data
);
   localparam int TOTAL   = 2 * HALF_POINTS;
   localparam int CNT_W   = $clog2(TOTAL);
   localparam int STEP_DIV = (HALF_POINTS / 2) < 1 ? 1 : HALF_POINTS / 2;
   localparam int DX_W    = RADIUS_WIDTH + 2;   // signed dx
   localparam int SUM_W   = ((COORD_WIDTH > DX_W) ? COORD_WIDTH : DX_W) + 2;
   localparam int TAG_W   = 3 * COORD_WIDTH + DX_W + 2;

   // Stall: the whole pipe moves when the output register can take data.
   logic advance;
   assign advance = !rsp_valid || rsp_ready;

   // ---- Sequencer: holds one circle and walks its points.
   logic                    busy_ff;
   logic [CNT_W-1:0]        k_ff;
   logic [COORD_WIDTH-1:0]  cx_ff, cy_ff, cz_ff;
   logic [RADIUS_WIDTH-1:0] r_ff;
   logic [DX_W-1:0]         dx_ff;        // running dx
   logic [RADIUS_WIDTH-1:0] step_ff;
   logic                    step_ok_ff;   // step computed
   logic                    issue;
   logic                    last_k;

   // step = floor(r / STEP_DIV) by reciprocal multiply, registered the cycle
   // after the transfer.
   localparam int RECIP_SH = RADIUS_WIDTH + 8;
   localparam logic [RECIP_SH:0] RECIP =
      (RECIP_SH+1)'(((64'd1 << RECIP_SH) + STEP_DIV - 1) / STEP_DIV);
   logic [RADIUS_WIDTH+RECIP_SH:0] prod;
   logic [RADIUS_WIDTH-1:0] q_est;
   logic [RADIUS_WIDTH+8:0] q_chk;
   logic [RADIUS_WIDTH-1:0] step_in;
   always_comb begin
      prod   = (RADIUS_WIDTH+RECIP_SH+1)'(r_ff) * (RADIUS_WIDTH+RECIP_SH+1)'(RECIP);
      q_est  = RADIUS_WIDTH'(prod >> RECIP_SH);
      q_chk  = (RADIUS_WIDTH+9)'(q_est) * (RADIUS_WIDTH+9)'(STEP_DIV);
      step_in = (q_chk > (RADIUS_WIDTH+9)'(r_ff)) ? q_est - 1'b1 : q_est;
   end

   assign last_k    = (k_ff == CNT_W'(TOTAL - 1));
   assign issue     = busy_ff && step_ok_ff && advance;
   assign req_ready = !busy_ff || (issue && last_k);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         step_ok_ff <= 1'b0;
         k_ff       <= '0;
      end else if (req_valid && req_ready) begin
         busy_ff    <= 1'b1;
         step_ok_ff <= 1'b0;
         k_ff       <= '0;
      end else if (busy_ff && !step_ok_ff) begin
         step_ok_ff <= 1'b1;
      end else if (issue) begin
         k_ff <= last_k ? '0 : k_ff + 1'b1;
         if (last_k) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cx_ff <= req_data.center_x;
         cy_ff <= req_data.center_y;
         cz_ff <= req_data.center_z;
         r_ff  <= req_data.radius;
         dx_ff <= DX_W'(req_data.radius);
      end else if (busy_ff && !step_ok_ff) begin
         step_ff <= step_in;
      end else if (issue) begin
         if (k_ff == CNT_W'(HALF_POINTS - 1))
            dx_ff <= -DX_W'(r_ff);
         else if (k_ff < CNT_W'(HALF_POINTS - 1))
            dx_ff <= dx_ff - DX_W'(step_ff);
         else
            dx_ff <= dx_ff + DX_W'(step_ff);
      end
   end

   // ---- Stage A: point issue register.
   logic                   a_vld_ff, a_up_ff, a_last_ff;
   logic [DX_W-1:0]        a_dx_ff;
   logic [COORD_WIDTH-1:0] a_cx_ff, a_cy_ff, a_cz_ff;
   logic [RADIUS_WIDTH-1:0] a_r_ff;
   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else if (advance) a_vld_ff <= issue;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         a_up_ff   <= (k_ff < CNT_W'(HALF_POINTS));
         a_last_ff <= last_k;
         a_dx_ff   <= dx_ff;
         a_cx_ff   <= cx_ff;
         a_cy_ff   <= cy_ff;
         a_cz_ff   <= cz_ff;
         a_r_ff    <= r_ff;
      end
   end

   // ---- Stage B: squares.
   logic                   b_vld_ff;
   logic [RR_WIDTH-1:0]    b_rr_ff, b_dd_ff;
   logic [TAG_W-1:0]       b_tag_ff;
   logic [RADIUS_WIDTH-1:0] a_adx;
   assign a_adx = a_dx_ff[DX_W-1] ? RADIUS_WIDTH'(-a_dx_ff) : RADIUS_WIDTH'(a_dx_ff);
   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else if (advance) b_vld_ff <= a_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         b_rr_ff  <= RR_WIDTH'(a_r_ff) * RR_WIDTH'(a_r_ff);
         b_dd_ff  <= RR_WIDTH'(a_adx) * RR_WIDTH'(a_adx);
         b_tag_ff <= {a_up_ff, a_last_ff, a_dx_ff, a_cx_ff, a_cy_ff, a_cz_ff};
      end
   end

   // ---- Stage C: radicand.
   logic                c_vld_ff;
   logic [RR_WIDTH-1:0] c_rad_ff;
   logic [TAG_W-1:0]    c_tag_ff;
   always_ff @(posedge clock) begin
      if (reset) c_vld_ff <= 1'b0;
      else if (advance) c_vld_ff <= b_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         c_rad_ff <= (b_rr_ff >= b_dd_ff) ? b_rr_ff - b_dd_ff : '0;
         c_tag_ff <= b_tag_ff;
      end
   end

   logic                    s_vld;
   logic [ROOT_WIDTH-1:0]   s_root;
   logic [TAG_W-1:0]        s_tag;
   cpi_sqrt #(.TAG_WIDTH(TAG_W)) u_sqrt (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(c_vld_ff), .in_rad(c_rad_ff), .in_tag(c_tag_ff),
      .out_valid(s_vld), .out_root(s_root), .out_tag(s_tag)
   );

   // ---- Output stage: sums and saturation.
   logic                          t_up, t_last;
   logic signed [DX_W-1:0]        t_dx;
   logic signed [COORD_WIDTH-1:0] t_cx, t_cy, t_cz;
   logic signed [SUM_W-1:0]       sx, sy;
   localparam logic signed [SUM_W-1:0] CMAX = SUM_W'((64'sd1 <<< (COORD_WIDTH-1)) - 1);
   localparam logic signed [SUM_W-1:0] CMIN = -CMAX - SUM_W'(1);
   always_comb begin
      {t_up, t_last, t_dx, t_cx, t_cy, t_cz} = s_tag;
      sx = SUM_W'(t_cx) + SUM_W'(t_dx);
      sy = t_up ? SUM_W'(t_cy) + $signed(SUM_W'(s_root))
                : SUM_W'(t_cy) - $signed(SUM_W'(s_root));
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (advance) rsp_valid <= s_vld;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data.point_x <= (sx > CMAX) ? COORD_WIDTH'(CMAX) :
                             (sx < CMIN) ? COORD_WIDTH'(CMIN) : COORD_WIDTH'(sx);
         rsp_data.point_y <= (sy > CMAX) ? COORD_WIDTH'(CMAX) :
                             (sy < CMIN) ? COORD_WIDTH'(CMIN) : COORD_WIDTH'(sy);
         rsp_data.point_z <= t_cz;
         rsp_data.last_point <= t_last;
      end
   end
endmodule
